// ===== rtl/miu_pkg.sv =====
// Package for the modular inverse unit: widths, controller commands and status types.
package miu_pkg;

    localparam int DataW       = 64;
    localparam int BitCntW     = $clog2(DataW);
    localparam int NewtonSteps = 6;
    localparam int StepCntW    = $clog2(NewtonSteps);

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_LOAD      = 4'd1,
        DP_DIV       = 4'd2,
        DP_BSET      = 4'd3,
        DP_MSTART_F  = 4'd4,
        DP_MSTART_N1 = 4'd5,
        DP_MSTART_N2 = 4'd6,
        DP_DBL       = 4'd7,
        DP_ADD       = 4'd8,
        DP_FEND      = 4'd9,
        DP_NEND      = 4'd10,
        DP_OUT       = 4'd11
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
        logic val_odd;
        logic exp_zero;
    } t_dp_stat;

endpackage

// ===== rtl/miu_if.sv =====
// Handshake channels of the modular inverse unit: input, result and configuration write.
interface miu_in_if import miu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DataW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface miu_out_if import miu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DataW-1:0] inverse;
    logic             not_invertible;

    modport source (output valid, output inverse, output not_invertible, input ready);
    modport sink   (input valid, input inverse, input not_invertible, output ready);
endinterface

interface miu_cfg_if import miu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DataW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/modular_inverse_unit.sv =====
// Modular inverse unit top level: Fermat inverse under a set modulus, Newton inverse mod 2^64.
//
// One 64-bit value is taken per transfer on i_in and one result leaves per transfer on
// o_out. With a nonzero modulus m the result is value^(m-2) mod m, computed right to left
// by square-and-multiply; the square and the multiply of each exponent bit run side by
// side in two shift-add modular multipliers that scan one multiplier bit per step
// (double, then conditional add). A value is first reduced by a restoring remainder,
// one bit a cycle.
// With a zero modulus (2^64) an odd value takes six Newton steps of two multiplications
// each; an even value returns zero with not_invertible set. One item is processed at a
// time; a finished result waits in an output register, so the next value is accepted
// while the result is not yet taken. Write the modulus on i_cfg only while the unit is
// idle; it resets to zero.
module modular_inverse_unit import miu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    miu_in_if.sink       i_in,
    miu_out_if.source    o_out,
    miu_cfg_if.sink      i_cfg
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    // Sequence the work of one item
    miu_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Hold the modulus and operands, run the modular arithmetic
    miu_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_value          (i_in.value),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_data       (i_cfg.data),
        .o_stat           (dp_stat),
        .o_inverse        (o_out.inverse),
        .o_not_invertible (o_out.not_invertible)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    // Configuration transfers complete at once
    assign i_cfg.ready = 1'b1;

endmodule

// ===== rtl/miu_datapath.sv =====
// Datapath of the modular inverse unit: modulus register, remainder and shift-add modular multipliers.
module miu_datapath import miu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [DataW-1:0] i_value,
    input  logic             i_cfg_we,
    input  logic [DataW-1:0] i_cfg_data,
    output t_dp_stat         o_stat,
    output logic [DataW-1:0] o_inverse,
    output logic             o_not_invertible
);

    logic [DataW-1:0] r_mod;
    logic [DataW-1:0] r_val;
    logic [DataW-1:0] r_r;
    logic [DataW-1:0] r_b;
    logic [DataW-1:0] r_e;
    logic [DataW-1:0] r_q;
    logic [DataW-1:0] r_a0;
    logic [DataW-1:0] r_acc0;
    logic [DataW-1:0] r_acc1;
    logic [DataW-1:0] r_inv;
    logic             r_err;

    logic             cin;
    logic [DataW-1:0] dbl0;
    logic [DataW-1:0] dbl1;
    logic [DataW-1:0] add0;
    logic [DataW-1:0] add1;
    logic             flag;

    // Reduce a sum below twice the modulus; a zero modulus wraps at 2^DataW
    function automatic logic [DataW-1:0] reduce(input logic [DataW:0] s,
                                                input logic [DataW-1:0] m);
        logic [DataW:0] d;
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[DataW-1:0] : s[DataW-1:0];
    endfunction

    assign cin  = (i_cmd.op == DP_DIV) ? r_q[DataW-1] : 1'b0;
    assign dbl0 = reduce({r_acc0, cin}, r_mod);
    assign dbl1 = reduce({r_acc1, 1'b0}, r_mod);
    assign add0 = reduce({1'b0, r_acc0} + {1'b0, r_a0}, r_mod);
    assign add1 = reduce({1'b0, r_acc1} + {1'b0, r_b}, r_mod);
    assign flag = (r_mod == '0) && !r_val[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_val  <= i_value;
                r_q    <= i_value;
                r_acc0 <= '0;
                r_e    <= r_mod - DataW'(2);
                r_r    <= (r_mod == DataW'(1)) ? '0 : DataW'(1);
            end
            DP_DIV: begin
                r_acc0 <= dbl0;
                r_q    <= r_q << 1;
            end
            DP_BSET: begin
                r_b <= r_acc0;
            end
            DP_MSTART_F: begin
                r_acc0 <= '0;
                r_acc1 <= '0;
                r_q    <= r_b;
                r_a0   <= r_r;
            end
            DP_MSTART_N1: begin
                r_acc0 <= '0;
                r_q    <= r_r;
                r_a0   <= r_val;
            end
            DP_MSTART_N2: begin
                r_acc0 <= '0;
                r_q    <= DataW'(2) - r_acc0;
                r_a0   <= r_r;
            end
            DP_DBL: begin
                r_acc0 <= dbl0;
                r_acc1 <= dbl1;
            end
            DP_ADD: begin
                if (r_q[DataW-1]) begin
                    r_acc0 <= add0;
                    r_acc1 <= add1;
                end
                r_q <= r_q << 1;
            end
            DP_FEND: begin
                if (r_e[0]) begin
                    r_r <= r_acc0;
                end
                r_b <= r_acc1;
                r_e <= r_e >> 1;
            end
            DP_NEND: begin
                r_r <= r_acc0;
            end
            DP_OUT: begin
                r_err <= flag;
                r_inv <= flag ? '0 : r_r;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.mod_zero  = (r_mod == '0);
    assign o_stat.val_odd   = r_val[0];
    assign o_stat.exp_zero  = (r_e == '0);
    assign o_inverse        = r_inv;
    assign o_not_invertible = r_err;

endmodule

// ===== rtl/miu_controller.sv =====
// Controller of the modular inverse unit: sequences remainder, exponentiation and Newton steps.
module miu_controller import miu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SEL    = 12'b0000_0000_0010,
        S_DIV    = 12'b0000_0000_0100,
        S_BSET   = 12'b0000_0000_1000,
        S_FCHK   = 12'b0000_0001_0000,
        S_DBL    = 12'b0000_0010_0000,
        S_ADD    = 12'b0000_0100_0000,
        S_FEND   = 12'b0000_1000_0000,
        S_NSTRT1 = 12'b0001_0000_0000,
        S_NSTRT2 = 12'b0010_0000_0000,
        S_NEND   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [BitCntW-1:0]  r_bit, n_bit;
    logic [StepCntW-1:0] r_step, n_step;
    logic                r_phase, n_phase;
    logic                r_out_valid, n_out_valid;
    logic                bit_last;

    assign bit_last    = (r_bit == BitCntW'(DataW - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_step      = r_step;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_SEL;
                end
            end
            S_SEL: begin
                n_bit  = '0;
                n_step = '0;
                if (!i_stat.mod_zero) begin
                    n_state = S_DIV;
                end else if (i_stat.val_odd) begin
                    n_state = S_NSTRT1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.op = DP_DIV;
                n_bit    = r_bit + 1'b1;
                if (bit_last) begin
                    n_state = S_BSET;
                end
            end
            S_BSET: begin
                o_cmd.op = DP_BSET;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.exp_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_MSTART_F;
                    n_bit    = '0;
                    n_state  = S_DBL;
                end
            end
            S_DBL: begin
                o_cmd.op = DP_DBL;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = DP_ADD;
                n_bit    = r_bit + 1'b1;
                if (!bit_last) begin
                    n_state = S_DBL;
                end else if (!i_stat.mod_zero) begin
                    n_state = S_FEND;
                end else if (!r_phase) begin
                    n_state = S_NSTRT2;
                end else begin
                    n_state = S_NEND;
                end
            end
            S_FEND: begin
                o_cmd.op = DP_FEND;
                n_state  = S_FCHK;
            end
            S_NSTRT1: begin
                o_cmd.op = DP_MSTART_N1;
                n_phase  = 1'b0;
                n_bit    = '0;
                n_state  = S_DBL;
            end
            S_NSTRT2: begin
                o_cmd.op = DP_MSTART_N2;
                n_phase  = 1'b1;
                n_bit    = '0;
                n_state  = S_DBL;
            end
            S_NEND: begin
                o_cmd.op = DP_NEND;
                n_step   = r_step + 1'b1;
                if (r_step == StepCntW'(NewtonSteps - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_NSTRT1;
                end
            end
            S_DONE: begin
                // hold until the result register is free or drains this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
            r_step      <= '0;
            r_phase     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bit       <= n_bit;
            r_step      <= n_step;
            r_phase     <= n_phase;
        end
    end

endmodule

// ===== rtl/miu_checker.sv =====
// Port-level checker of the modular inverse unit, bound to the top level.
module miu_checker import miu_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [DataW-1:0] i_inverse,
    input logic             i_not_invertible
);

    // Hold a pending result until it transfers
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_inverse) && $stable(i_not_invertible)))
        else $error("pending result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_not_invertible) |-> (i_inverse == '0))
        else $error("flagged result carries nonzero inverse");

    // An accepted value keeps the unit busy for at least the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while busy");

    // A new result appears only as the unit returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result raised while unit busy");

endmodule

bind modular_inverse_unit miu_checker u_miu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_inverse        (o_out.inverse),
    .i_not_invertible (o_out.not_invertible)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the modular inverse unit: Fermat and Newton modes.
`timescale 1ns / 100ps

module tb_top;
    import miu_pkg::*;

    localparam int          NEWTON_ITERS = 6;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES  = 200;
    // Worst case is ~105 items of the longest exponent loop plus stalls; allow several times that.
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;

    localparam logic [DataW-1:0] ALL_ONES  = {DataW{1'b1}};
    localparam logic [DataW-1:0] TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

    // One expected result, kept with the value that caused it for reporting.
    typedef struct {
        logic [DataW-1:0] value;
        logic [DataW-1:0] inverse;
        logic             not_invertible;
    } t_inv_expect;

    logic i_clk = 1'b0;
    logic i_rst_n;

    miu_in_if  in_if ();
    miu_out_if out_if ();
    miu_cfg_if cfg_if ();

    modular_inverse_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Testbench copy of the modulus register and the queue of pending inverses.
    logic [DataW-1:0] modulus_q = '0;
    t_inv_expect      pending_inverses[$];
    int               err_count = 0;

    // Idle percentages for the sender and the receiver.
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    // A change of hold_tag asks the receiver to hold ready low for a long hold-off.
    int unsigned hold_tag  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_cnt  = 0;

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Full 128-bit product reduced by a nonzero modulus.
    function automatic logic [DataW-1:0] mul_reduce(input logic [DataW-1:0] a,
                                                    input logic [DataW-1:0] b,
                                                    input logic [DataW-1:0] m);
        logic [2*DataW-1:0] prod;
        prod = {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
        prod = prod % {{DataW{1'b0}}, m};
        return prod[DataW-1:0];
    endfunction

    // value^(m-2) mod m, right to left; the exponent wraps for m == 1.
    function automatic logic [DataW-1:0] fermat_power(input logic [DataW-1:0] v,
                                                      input logic [DataW-1:0] m);
        logic [DataW-1:0] acc;
        logic [DataW-1:0] base;
        logic [DataW-1:0] expo;
        acc  = 64'd1;
        base = v % m;
        expo = m - 64'd2;
        while (expo != '0) begin
            if (expo[0]) begin
                acc = mul_reduce(acc, base, m);
            end
            base = mul_reduce(base, base, m);
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Newton iteration mod 2^64 from x = 1; wraps naturally at 64 bits.
    function automatic logic [DataW-1:0] newton_recip(input logic [DataW-1:0] v);
        logic [DataW-1:0] x;
        x = 64'd1;
        for (int i = 0; i < NEWTON_ITERS; i++) begin
            x = x * (64'd2 - v * x);
        end
        return x;
    endfunction

    function automatic t_inv_expect predict_inverse(input logic [DataW-1:0] v);
        t_inv_expect res;
        res.value = v;
        if (modulus_q != '0) begin
            res.inverse        = fermat_power(v, modulus_q);
            res.not_invertible = 1'b0;
        end else if (!v[0]) begin
            res.inverse        = '0;
            res.not_invertible = 1'b1;
        end else begin
            res.inverse        = newton_recip(v);
            res.not_invertible = 1'b0;
        end
        return res;
    endfunction

    // Mostly full-width random, with small and near-max values mixed in.
    function automatic logic [DataW-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return DataW'($urandom_range(0, 15));
        end else if (pick < 30) begin
            return {32'hFFFF_FFFF, $urandom};
        end
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Sender, configuration and drain
    // ------------------------------------------------------------------

    // Offer one value, idling at random first; hold valid high across back-to-back items.
    task automatic send_value(input logic [DataW-1:0] v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        // Transfer happened at this edge: record what must come back.
        pending_inverses.push_back(predict_inverse(v));
    endtask

    // Drop valid, wait until every pending inverse has come back, then let the unit settle.
    task automatic wait_idle(input int settle);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_inverses.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write the modulus register; call only with the unit idle.
    task automatic write_modulus(input logic [DataW-1:0] m);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= m;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        modulus_q = m;
    endtask

    // Drain, then move to a new modulus.
    task automatic switch_modulus(input logic [DataW-1:0] m);
        wait_idle(SETTLE_CYCLES);
        write_modulus(m);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, with a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_tag) begin
            hold_seen    <= hold_tag;
            hold_cnt     <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt     <= hold_cnt - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest pending inverse
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_inv_expect exp_res;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_inverses.size() == 0) begin
                $display("%0t: error: unexpected result inverse %h not_invertible %b",
                         $time, out_if.inverse, out_if.not_invertible);
                err_count++;
            end else begin
                exp_res = pending_inverses.pop_front();
                if (out_if.inverse !== exp_res.inverse) begin
                    $display("%0t: error: inverse of %h mod %h: expected %h, actual %h",
                             $time, exp_res.value, modulus_q, exp_res.inverse,
                             out_if.inverse);
                    err_count++;
                end
                if (out_if.not_invertible !== exp_res.not_invertible) begin
                    $display("%0t: error: not_invertible for %h: expected %b, actual %b",
                             $time, exp_res.value, exp_res.not_invertible,
                             out_if.not_invertible);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: count cycles and end the run at the limit.
    initial begin
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: error: timeout with %0d results pending", $time,
                 pending_inverses.size());
        $display("FAIL modular_inverse_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Modulus 2^64 straight out of reset: unit values, extremes, even values.
    task automatic test_newton_corners();
        logic [DataW-1:0] corner_vals[8];
        corner_vals = '{64'd1, 64'd3, ALL_ONES, 64'd0, 64'd2, 64'h8000_0000_0000_0000,
                        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        foreach (corner_vals[i]) begin
            send_value(corner_vals[i]);
        end
    endtask

    // Modulus one, modulus two, tiny and top primes, an all-ones and a small composite.
    task automatic test_fermat_corners();
        logic [DataW-1:0] mods[15];
        logic [DataW-1:0] vals[15];
        mods = '{64'd1, 64'd1, 64'd2, 64'd2, 64'd2, 64'd3, 64'd3, 64'd3, 64'd3,
                 TOP_PRIME, TOP_PRIME, TOP_PRIME, ALL_ONES, 64'd15, 64'd15};
        vals = '{64'd5, 64'd0, 64'd0, 64'd1, ALL_ONES, 64'd0, 64'd1, 64'd2, ALL_ONES,
                 64'd1, ALL_ONES, TOP_PRIME - 64'd1, 64'd2, 64'd7, 64'd5};
        foreach (mods[i]) begin
            // Change the modulus only with nothing in flight.
            if (mods[i] != modulus_q) begin
                switch_modulus(mods[i]);
            end
            send_value(vals[i]);
        end
    endtask

    // Random values under modulus 2^64, both odd and even.
    task automatic test_newton_random();
        switch_modulus('0);
        repeat (15) begin
            send_value(rand_value());
        end
    endtask

    // Random small moduli, one full-width group; some values share a factor with m.
    task automatic test_fermat_random();
        logic [DataW-1:0] m;
        logic [DataW-1:0] v;
        for (int grp = 0; grp < 6; grp++) begin
            if (grp == 4) begin
                m = {1'b1, $urandom, 31'($urandom)};
            end else begin
                m = DataW'($urandom_range(3, 65535));
            end
            switch_modulus(m);
            repeat (5) begin
                if ($urandom_range(0, 4) == 0) begin
                    v = m * DataW'($urandom_range(0, 3));
                end else begin
                    v = rand_value();
                end
                send_value(v);
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_output_backpressure();
        switch_modulus('0);
        hold_tag <= hold_tag + 1;
        repeat (9) begin
            send_value(rand_value() & ~64'd1);
        end
        repeat (3) begin
            send_value(rand_value() | 64'd1);
        end
        // Pause the sender until every result has drained.
        wait_idle(SETTLE_CYCLES);
    endtask

    // Random moduli of every size class, no idling on either side.
    task automatic test_mixed_random();
        logic [DataW-1:0] m;
        int unsigned      pick;
        for (int grp = 0; grp < 5; grp++) begin
            pick = $urandom_range(0, 7);
            if (pick < 2) begin
                m = '0;
            end else if (pick < 4) begin
                m = DataW'($urandom_range(1, 16));
            end else if (pick < 7) begin
                m = DataW'($urandom_range(17, 24'hFF_FFFF));
            end else begin
                m = {$urandom, $urandom};
            end
            switch_modulus(m);
            repeat (5) begin
                send_value(rand_value());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value from time zero.
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.value    = '0;
        out_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles a third of the time, receiver most of the time.
        src_idle_pct = 33;
        snk_idle_pct = 73;
        test_newton_corners();
        test_fermat_corners();
        test_newton_random();

        // Swap the idle rates.
        wait_idle(SETTLE_CYCLES);
        src_idle_pct = 73;
        snk_idle_pct = 33;
        test_fermat_random();

        // Full rate on both sides.
        wait_idle(SETTLE_CYCLES);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_output_backpressure();
        test_mixed_random();

        // Drain, then watch for stray results.
        wait_idle(TAIL_CYCLES);
        if (err_count == 0) begin
            $display("PASS modular_inverse_unit");
        end else begin
            $display("FAIL modular_inverse_unit");
        end
        $finish;
    end

endmodule

// ===== modular_inverse_unit.f =====
rtl/miu_pkg.sv
rtl/miu_if.sv
rtl/miu_datapath.sv
rtl/miu_controller.sv
rtl/modular_inverse_unit.sv
rtl/miu_checker.sv
test/tb_top.sv
